// File: rtl/ttuv_pkg.sv
// ----------------------------------------------------------------------------
// ttuv_pkg
// Shared types and widths for the per-triangle tangent block.
// ----------------------------------------------------------------------------
package ttuv_pkg;

    localparam int COORD_WIDTH       = 32;
    localparam int TANGENT_FRAC_BITS = 14;
    localparam int OUT_WIDTH         = 16;

    // edge and uv deltas, their products, and the tangent before normalizing
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int TW     = PROD_W + 1;

    // after normalizing, the largest component sits in [2^(C_BITS-1), 2^C_BITS)
    localparam int C_BITS     = 31;
    localparam int SUM_W      = 64;
    localparam int NUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = TANGENT_FRAC_BITS + 1;
    localparam int STEP_W     = 6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SIGN,
        ST_NORM,
        ST_SQ,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } ttuv_state_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } ttuv_op_t;

    typedef struct packed {
        logic     start;
        ttuv_op_t op;
    } ttuv_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ttuv_stat_t;

endpackage

// File: rtl/ttuv_rootdiv.sv
// ----------------------------------------------------------------------------
// ttuv_rootdiv
// Iterative unit: integer square root (two bits per step) or restoring
// divide (one quotient bit per step) on a shared set of registers.
// ----------------------------------------------------------------------------
module ttuv_rootdiv
    import ttuv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ttuv_cmd_t         cmd,
    input  logic [NUM_W-1:0]  num,
    input  logic [ROOT_W-1:0] den,
    output ttuv_stat_t        stat,
    output logic [ROOT_W-1:0] result
);

    logic              busy_reg;
    logic              done_reg;
    ttuv_op_t          op_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  acc_reg;
    logic [NUM_W-1:0]  res_reg;
    logic [NUM_W-1:0]  bit_reg;
    logic [ROOT_W-1:0] den_reg;

    logic [NUM_W-1:0]  trial;
    logic              sq_ge;
    logic [ROOT_W:0]   shifted;
    logic              dv_ge;

    assign trial   = res_reg + bit_reg;
    assign sq_ge   = (acc_reg >= trial);
    assign shifted = {acc_reg[ROOT_W-1:0], bit_reg[DIV_STEPS-1]};
    assign dv_ge   = (shifted >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= (cmd.op == OP_SQRT) ? STEP_W'(SQRT_STEPS - 1)
                                                : STEP_W'(DIV_STEPS - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= cmd.op;
            den_reg <= den;
            res_reg <= '0;
            if (cmd.op == OP_SQRT)
            begin
                acc_reg <= num;
                bit_reg <= NUM_W'(1) << (NUM_W - 2);
            end
            else
            begin
                // upper part is below den since the quotient fits DIV_STEPS bits
                acc_reg <= num >> DIV_STEPS;
                bit_reg <= num;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_SQRT)
            begin
                if (sq_ge)
                begin
                    acc_reg <= acc_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            else
            begin
                acc_reg <= dv_ge ? NUM_W'(shifted - {1'b0, den_reg}) : NUM_W'(shifted);
                bit_reg <= bit_reg << 1;
                res_reg <= {res_reg[NUM_W-2:0], dv_ge};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg[ROOT_W-1:0];

endmodule

// File: rtl/triangle_tangent_from_uv.sv
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv
// Takes triangle corners one per item and, on every third corner, returns
// the unit tangent from the uv gradients in signed Q2.14.
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_ready  | pos_x, pos_y, pos_z, tex_u, tex_v
//   out     | out_valid / out_ready| tangent_x/y/z, degenerate
//
// A third corner starts the sequencer: the shared multiplier forms det and
// T, then come signs, normalizing shifts, the sum of squares, the square
// root, one divide per component and the load of the output; a degenerate
// triangle goes from signs straight to the output. Root and divide run on
// one iterative unit. in_ready is low from a third corner until the
// sequencer is back in idle. A waiting result holds out_valid; the next
// triangle is still taken and worked on, and its result waits in the done
// state until the output register is free.
// Reset clears the corner count and all control; stored corners are not reset.
// ----------------------------------------------------------------------------
module triangle_tangent_from_uv
    import ttuv_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    input  logic signed [COORD_WIDTH-1:0] tex_u,
    input  logic signed [COORD_WIDTH-1:0] tex_v,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [OUT_WIDTH-1:0]   tangent_x,
    output logic signed [OUT_WIDTH-1:0]   tangent_y,
    output logic signed [OUT_WIDTH-1:0]   tangent_z,
    output logic                          degenerate
);

    function automatic logic signed [DIFF_W-1:0] sdiff(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        sdiff = DIFF_W'(a) - DIFF_W'(b);
    endfunction

    ttuv_state_t state_reg, state_next;

    logic [1:0]  cnt_reg;
    logic [3:0]  k_reg;
    logic [1:0]  j_reg;
    logic [1:0]  i_reg;
    logic        go_reg;
    logic        out_valid_reg;
    logic        in_acc;
    logic        done_go;

    logic signed [COORD_WIDTH-1:0] pos_in [3];
    logic signed [COORD_WIDTH-1:0] p1_reg [3];
    logic signed [COORD_WIDTH-1:0] p2_reg [3];
    logic signed [COORD_WIDTH-1:0] uv1_reg [2];
    logic signed [COORD_WIDTH-1:0] uv2_reg [2];

    logic signed [DIFF_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [DIFF_W-1:0] e1_reg [3];
    logic signed [DIFF_W-1:0] e2_reg [3];

    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [TW-1:0]     acc_reg;
    logic signed [TW-1:0]     det_reg;
    logic        [TW-1:0]     m_reg [3];
    logic                     neg_reg [3];
    logic                     deg_reg;
    logic        [SUM_W-1:0]  sum_reg;
    logic        [ROOT_W-1:0] len_reg;
    logic        [OUT_WIDTH-1:0] q_reg [3];

    logic [OUT_WIDTH-1:0] tan_reg [3];
    logic                 deg_out_reg;

    logic [TW-1:0]     abs_m [3];
    logic              sign_deg;
    logic [TW-1:0]     norm_or;
    logic              norm_high;
    logic              norm_low;
    logic [1:0]        e_idx;
    logic [1:0]        t_idx;
    logic signed [TW-1:0] pair_diff;

    ttuv_cmd_t         cmd;
    ttuv_stat_t        stat;
    logic [NUM_W-1:0]  unit_num;
    logic [ROOT_W-1:0] unit_res;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    assign in_acc = in_valid && in_ready;

    // hold the finished result until the output register is free
    assign done_go = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        for (int n = 0; n < 3; n++)
        begin
            abs_m[n] = m_reg[n][TW-1] ? (~m_reg[n] + 1'b1) : m_reg[n];
        end
    end

    assign sign_deg  = (det_reg == '0) || ((abs_m[0] | abs_m[1] | abs_m[2]) == '0);
    assign norm_or   = m_reg[0] | m_reg[1] | m_reg[2];
    assign norm_high = |norm_or[TW-1:C_BITS];
    assign norm_low  = !norm_or[C_BITS-1];
    assign e_idx     = 2'((k_reg >> 1) - 4'd1);
    assign t_idx     = 2'((k_reg >> 1) - 4'd2);
    assign pair_diff = acc_reg - TW'(prod_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = du1_reg;
        mul_b = dv2_reg;
        if (state_reg == ST_SQ)
        begin
            mul_a = DIFF_W'(m_reg[(j_reg == 2'd3) ? 2'd0 : j_reg][C_BITS-1:0]);
            mul_b = mul_a;
        end
        else if (k_reg == 4'd1)
        begin
            mul_a = dv1_reg;
            mul_b = du2_reg;
        end
        else if (k_reg >= 4'd2 && k_reg <= 4'd7)
        begin
            mul_a = k_reg[0] ? dv1_reg : dv2_reg;
            mul_b = k_reg[0] ? e2_reg[e_idx] : e1_reg[e_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign unit_num = (state_reg == ST_ROOT) ? sum_reg
                    : ((NUM_W'(m_reg[i_reg][C_BITS-1:0]) << TANGENT_FRAC_BITS)
                       + NUM_W'(len_reg >> 1));

    ttuv_rootdiv u_rootdiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .num    (unit_num),
        .den    (len_reg),
        .stat   (stat),
        .result (unit_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_acc && cnt_reg == 2'd2) state_next = ST_MUL;
            ST_MUL:  if (k_reg == 4'd8) state_next = ST_SIGN;
            ST_SIGN: state_next = sign_deg ? ST_DONE : ST_NORM;
            ST_NORM: if (!norm_high && !norm_low) state_next = ST_SQ;
            ST_SQ:   if (j_reg == 2'd3) state_next = ST_ROOT;
            ST_ROOT: if (stat.done) state_next = ST_DIV;
            ST_DIV:  if (stat.done && i_reg == 2'd2) state_next = ST_DONE;
            ST_DONE: if (done_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        cmd.start = 1'b0;
        cmd.op    = OP_SQRT;
        unique case (state_reg)
            ST_IDLE: in_ready  = 1'b1;
            ST_ROOT: cmd.start = go_reg;
            ST_DIV:
            begin
                cmd.start = go_reg;
                cmd.op    = OP_DIV;
            end
            default: in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            i_reg         <= '0;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= 1'b0;
            if (in_acc)
            begin
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
                k_reg   <= '0;
            end
            if (state_reg == ST_MUL)
            begin
                k_reg <= k_reg + 4'd1;
            end
            if (state_reg == ST_NORM)
            begin
                j_reg <= '0;
            end
            if (state_reg == ST_SQ)
            begin
                j_reg <= j_reg + 2'd1;
                go_reg <= (j_reg == 2'd3);
            end
            if (state_reg == ST_ROOT && stat.done)
            begin
                i_reg  <= '0;
                go_reg <= 1'b1;
            end
            if (state_reg == ST_DIV && stat.done && i_reg != 2'd2)
            begin
                i_reg  <= i_reg + 2'd1;
                go_reg <= 1'b1;
            end
            if (done_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            unique case (cnt_reg)
                2'd0:
                begin
                    p1_reg     <= pos_in;
                    uv1_reg[0] <= tex_u;
                    uv1_reg[1] <= tex_v;
                end
                2'd1:
                begin
                    p2_reg     <= pos_in;
                    uv2_reg[0] <= tex_u;
                    uv2_reg[1] <= tex_v;
                end
                default:
                begin
                    du1_reg <= sdiff(uv2_reg[0], uv1_reg[0]);
                    dv1_reg <= sdiff(uv2_reg[1], uv1_reg[1]);
                    du2_reg <= sdiff(tex_u, uv1_reg[0]);
                    dv2_reg <= sdiff(tex_v, uv1_reg[1]);
                    for (int n = 0; n < 3; n++)
                    begin
                        e1_reg[n] <= sdiff(p2_reg[n], p1_reg[n]);
                        e2_reg[n] <= sdiff(pos_in[n], p1_reg[n]);
                    end
                end
            endcase
        end

        // products land in the cycle after issue; pair them up
        if (state_reg == ST_MUL && k_reg != 4'd0)
        begin
            if (k_reg[0])
            begin
                acc_reg <= TW'(prod_reg);
            end
            else if (k_reg == 4'd2)
            begin
                det_reg <= pair_diff;
            end
            else
            begin
                m_reg[t_idx] <= pair_diff;
            end
        end

        if (state_reg == ST_SIGN)
        begin
            deg_reg <= sign_deg;
            for (int n = 0; n < 3; n++)
            begin
                m_reg[n]   <= abs_m[n];
                neg_reg[n] <= m_reg[n][TW-1] ^ det_reg[TW-1];
            end
        end

        // bring the largest component into the top bit of C_BITS
        if (state_reg == ST_NORM)
        begin
            for (int n = 0; n < 3; n++)
            begin
                if (norm_high)
                begin
                    m_reg[n] <= m_reg[n] >> 1;
                end
                else if (norm_low)
                begin
                    m_reg[n] <= m_reg[n] << 1;
                end
            end
        end

        if (state_reg == ST_SQ && j_reg != 2'd0)
        begin
            sum_reg <= ((j_reg == 2'd1) ? '0 : sum_reg) + prod_reg[SUM_W-1:0];
        end

        if (state_reg == ST_ROOT && stat.done)
        begin
            len_reg <= unit_res;
        end

        if (state_reg == ST_DIV && stat.done)
        begin
            q_reg[i_reg] <= unit_res[OUT_WIDTH-1:0];
        end

        if (done_go)
        begin
            deg_out_reg <= deg_reg;
            for (int n = 0; n < 3; n++)
            begin
                if (deg_reg)
                begin
                    tan_reg[n] <= '0;
                end
                else
                begin
                    tan_reg[n] <= neg_reg[n] ? (~q_reg[n] + 1'b1) : q_reg[n];
                end
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign tangent_x  = tan_reg[0];
    assign tangent_y  = tan_reg[1];
    assign tangent_z  = tan_reg[2];
    assign degenerate = deg_out_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("in_ready outside idle");

    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && degenerate) |->
        (tangent_x == '0 && tangent_y == '0 && tangent_z == '0))
        else $error("degenerate item with nonzero tangent");

    a_unit_done: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == ST_ROOT || state_reg == ST_DIV))
        else $error("unit finished outside root or divide");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> (!norm_high && !norm_low))
        else $error("components not normalized");

    a_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !stat.busy)
        else $error("unit started while busy");

endmodule
